/* rtl/lcfp_pkg.sv */
// ----------------------------------------------------------------------------
// lcfp_pkg
// Shared types and constants for the lighting channel frame parser.
// ----------------------------------------------------------------------------
package lcfp_pkg;

  localparam int CHANNELS = 512;
  localparam int IDX_W    = $clog2(CHANNELS);
  localparam int CNT_W    = $clog2(CHANNELS + 1);
  localparam int SEND_W   = 10;
  localparam int RIDX_W   = 9;

  localparam logic [7:0] BYTE_FULL_HDR = 8'hFF;
  localparam logic [7:0] BYTE_ONE_HDR  = 8'hFE;
  localparam logic [7:0] BYTE_SECOND   = 8'h00;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic MODE_BYTE = 1'b0;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_SECOND   = 4'd1,
    PH_CNT_H    = 4'd2,
    PH_CNT_L    = 4'd3,
    PH_CH_H     = 4'd4,
    PH_CH_L     = 4'd5,
    PH_VALUE    = 4'd6,
    PH_DATA     = 4'd7,
    PH_FULL_CHK = 4'd8,
    PH_ONE_CHK  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_COMMIT,
    CS_EMIT_STAT,
    CS_EMIT_READ
  } ctl_state_t;

  // Byte operation applied by the datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_XOR_CLR,
    OP_CNT_H,
    OP_CNT_L,
    OP_DATA,
    OP_CH_H,
    OP_CH_L,
    OP_VALUE,
    OP_ONE_WR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic set_err;
    logic err_val;
    logic rd_en;
    logic sweep_clr;
    logic sweep_inc;
    logic clr_wr;
    logic cp_rd;
    logic load_stat;
    logic load_read;
  } cmd_t;

  typedef struct packed {
    logic cnt_bad;
    logic fill_last;
    logic xor_ok;
    logic chan_bad;
    logic clr_last;
    logic cp_last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/lcfp_ram.sv */
// ----------------------------------------------------------------------------
// lcfp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* rtl/lcfp_dpath.sv */
// ----------------------------------------------------------------------------
// lcfp_dpath
// Frame datapath: count, checksum and fill registers, staging and live
// channel stores, commit and clear sweep, output register.
// ----------------------------------------------------------------------------
module lcfp_dpath
  import lcfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [7:0]        in_rx_byte,
  input  logic [RIDX_W-1:0] in_read_index,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_kind,
  output logic              out_status,
  output logic [SEND_W-1:0] out_send_count,
  output logic [7:0]        out_read_value
);

  logic [15:0]      cnt_r;
  logic [7:0]       xor_r;
  logic [CNT_W-1:0] fill_r;
  logic [7:0]       pend_r;
  logic             err_r;
  logic             rd_ok_r;
  logic [IDX_W-1:0] cidx_r;
  logic             cp_wr_r;
  logic [IDX_W-1:0] cp_idx_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic              out_status_r;
  logic [SEND_W-1:0] out_send_r;
  logic [7:0]        out_value_r;

  logic [15:0]      cnt_new;
  logic [15:0]      fill_inc;
  logic [15:0]      cidx_inc;
  logic [15:0]      chan_m1;
  logic [7:0]       stg_rdata;
  logic [7:0]       live_rdata;
  logic             stg_wr;
  logic             live_wr;
  logic [IDX_W-1:0] live_waddr;
  logic [7:0]       live_wdata;

  assign cnt_new  = {cnt_r[15:8], in_rx_byte};
  assign fill_inc = 16'(fill_r) + 16'd1;
  assign cidx_inc = 16'(cidx_r) + 16'd1;
  assign chan_m1  = cnt_r - 16'd1;

  always_comb begin
    stat.cnt_bad   = (cnt_new == 16'd0) || (cnt_new > 16'(CHANNELS));
    stat.fill_last = (fill_inc >= cnt_r);
    stat.xor_ok    = (in_rx_byte == xor_r);
    stat.chan_bad  = (cnt_r == 16'd0) || (cnt_r > 16'(CHANNELS));
    stat.clr_last  = (cidx_r == IDX_W'(CHANNELS - 1));
    stat.cp_last   = (cidx_inc >= cnt_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign stg_wr = (cmd.op == OP_DATA) && (fill_r < CNT_W'(CHANNELS));

  // Live store write source: clearing sweep, commit copy or single update
  always_comb begin
    live_wr    = 1'b0;
    live_waddr = cidx_r;
    live_wdata = 8'd0;
    if (cmd.clr_wr) begin
      live_wr = 1'b1;
    end else if (cp_wr_r) begin
      live_wr    = 1'b1;
      live_waddr = cp_idx_r;
      live_wdata = stg_rdata;
    end else if (cmd.op == OP_ONE_WR) begin
      live_wr    = 1'b1;
      live_waddr = chan_m1[IDX_W-1:0];
      live_wdata = pend_r;
    end
  end

  lcfp_ram #(
    .WIDTH (8),
    .DEPTH (CHANNELS)
  ) u_stage_ram (
    .clk     (clk),
    .wr_en   (stg_wr),
    .wr_addr (fill_r[IDX_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (cmd.cp_rd),
    .rd_addr (cidx_r),
    .rd_data (stg_rdata)
  );

  lcfp_ram #(
    .WIDTH (8),
    .DEPTH (CHANNELS)
  ) u_live_ram (
    .clk     (clk),
    .wr_en   (live_wr),
    .wr_addr (live_waddr),
    .wr_data (live_wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (IDX_W'(in_read_index)),
    .rd_data (live_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      xor_r    <= '0;
      fill_r   <= '0;
      pend_r   <= '0;
      err_r    <= 1'b0;
      cidx_r   <= '0;
      cp_wr_r  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_XOR_CLR: xor_r <= '0;
        OP_CNT_H: begin
          cnt_r <= {in_rx_byte, 8'd0};
          xor_r <= xor_r ^ in_rx_byte;
        end
        OP_CNT_L: begin
          cnt_r  <= cnt_new;
          xor_r  <= xor_r ^ in_rx_byte;
          fill_r <= '0;
        end
        OP_DATA: begin
          fill_r <= fill_r + CNT_W'(1);
          xor_r  <= xor_r ^ in_rx_byte;
        end
        OP_CH_H: begin
          cnt_r <= {in_rx_byte, 8'd0};
          xor_r <= in_rx_byte;
        end
        OP_CH_L: begin
          cnt_r <= cnt_new;
          xor_r <= xor_r ^ in_rx_byte;
        end
        OP_VALUE: begin
          pend_r <= in_rx_byte;
          xor_r  <= xor_r ^ in_rx_byte;
        end
        default: ;
      endcase
      if (cmd.set_err) begin
        err_r <= cmd.err_val;
      end
      if (cmd.sweep_clr) begin
        cidx_r <= '0;
      end else if (cmd.sweep_inc) begin
        cidx_r <= cidx_r + IDX_W'(1);
      end
      // staging read data lands in the cycle after the read
      cp_wr_r <= cmd.cp_rd;
    end
  end

  always_ff @(posedge clk) begin
    cp_idx_r <= cidx_r;
    if (cmd.rd_en) begin
      rd_ok_r <= (32'(in_read_index) < CHANNELS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_stat || cmd.load_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_stat) begin
      out_kind_r   <= KIND_STATUS;
      out_status_r <= err_r;
      out_send_r   <= err_r ? '0 : cnt_r[SEND_W-1:0];
      out_value_r  <= 8'd0;
    end else if (cmd.load_read) begin
      out_kind_r   <= KIND_READ;
      out_status_r <= 1'b0;
      out_send_r   <= '0;
      out_value_r  <= rd_ok_r ? live_rdata : 8'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_status     = out_status_r;
  assign out_send_count = out_send_r;
  assign out_read_value = out_value_r;

endmodule

/* rtl/lcfp_ctrl.sv */
// ----------------------------------------------------------------------------
// lcfp_ctrl
// Controller: transaction sequencing, frame parse phase, clear and commit
// sweeps, result hand-off to the output register.
// ----------------------------------------------------------------------------
module lcfp_ctrl
  import lcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_mode,
  input  logic [7:0] in_rx_byte,
  output logic       in_ready,
  output cmd_t       cmd,
  input  stat_t      stat
);

  ctl_state_t state_r, state_nxt;
  phase_t     ph_r, ph_nxt;
  logic       accept;
  logic       one_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_CLEAR;
      ph_r    <= PH_HEADER;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  assign in_ready = (state_r == CS_IDLE);
  assign accept   = in_valid && in_ready;
  assign one_err  = !stat.xor_ok || stat.chan_bad;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    case (state_r)
      CS_CLEAR: begin
        cmd.clr_wr    = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (stat.clr_last) begin
          cmd.sweep_clr = 1'b1;
          state_nxt     = CS_IDLE;
        end
      end
      CS_IDLE: begin
        if (accept && (in_mode != MODE_BYTE)) begin
          cmd.rd_en = 1'b1;
          state_nxt = CS_EMIT_READ;
        end else if (accept) begin
          case (ph_r)
            PH_SECOND: ph_nxt = (in_rx_byte == BYTE_SECOND) ? PH_CNT_H : PH_HEADER;
            PH_CNT_H: begin
              cmd.op = OP_CNT_H;
              ph_nxt = PH_CNT_L;
            end
            PH_CNT_L: begin
              cmd.op = OP_CNT_L;
              ph_nxt = stat.cnt_bad ? PH_HEADER : PH_DATA;
            end
            PH_DATA: begin
              cmd.op = OP_DATA;
              if (stat.fill_last) begin
                ph_nxt = PH_FULL_CHK;
              end
            end
            PH_FULL_CHK: begin
              ph_nxt      = PH_HEADER;
              cmd.set_err = 1'b1;
              cmd.err_val = !stat.xor_ok;
              if (stat.xor_ok) begin
                cmd.sweep_clr = 1'b1;
                state_nxt     = CS_COMMIT;
              end else begin
                state_nxt = CS_EMIT_STAT;
              end
            end
            PH_CH_H: begin
              cmd.op = OP_CH_H;
              ph_nxt = PH_CH_L;
            end
            PH_CH_L: begin
              cmd.op = OP_CH_L;
              ph_nxt = PH_VALUE;
            end
            PH_VALUE: begin
              cmd.op = OP_VALUE;
              ph_nxt = PH_ONE_CHK;
            end
            PH_ONE_CHK: begin
              ph_nxt      = PH_HEADER;
              cmd.set_err = 1'b1;
              cmd.err_val = one_err;
              if (!one_err) begin
                cmd.op = OP_ONE_WR;
              end
              state_nxt = CS_EMIT_STAT;
            end
            default: begin
              // header wait; unused phase codes land here too
              if (in_rx_byte == BYTE_FULL_HDR) begin
                cmd.op = OP_XOR_CLR;
                ph_nxt = PH_SECOND;
              end else if (in_rx_byte == BYTE_ONE_HDR) begin
                ph_nxt = PH_CH_H;
              end else begin
                ph_nxt = PH_HEADER;
              end
            end
          endcase
        end
      end
      CS_COMMIT: begin
        // one staging read per cycle, live write follows in the next cycle
        cmd.cp_rd     = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (stat.cp_last) begin
          cmd.sweep_clr = 1'b1;
          state_nxt     = CS_EMIT_STAT;
        end
      end
      CS_EMIT_STAT: begin
        if (stat.out_free) begin
          cmd.load_stat = 1'b1;
          state_nxt     = CS_IDLE;
        end
      end
      CS_EMIT_READ: begin
        if (stat.out_free) begin
          cmd.load_read = 1'b1;
          state_nxt     = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule

/* rtl/lighting_channel_frame_parser.sv */
// ----------------------------------------------------------------------------
// lighting_channel_frame_parser
// Serial frame parser feeding a live lighting channel store.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): with in_mode 0 each transaction carries
// one host byte in in_rx_byte; with in_mode 1 it reads live channel
// in_read_index for the line transmitter. Output channel (out_valid/
// out_ready) returns a frame status (out_kind 0) or read data (out_kind 1).
// Sequencing, set by the controller states and the registered RAM reads:
//   - a byte that completes no frame: next byte taken at once;
//   - a read: in_ready drops; the registered live RAM read goes to the
//     output register from CS_EMIT_READ;
//   - a single update or failed full frame: CS_EMIT_STAT loads the status;
//   - a good full frame of N channels: the commit copies one channel per
//     cycle, then CS_EMIT_STAT loads the status.
// After reset a clearing pass writes zero to all 512 live channels, one per
// cycle; in_ready stays low until the pass ends.
// A result sits in the output register until taken. While it waits the
// parser keeps taking bytes; only a new result stalls the input, until the
// output register frees.
// ----------------------------------------------------------------------------
module lighting_channel_frame_parser
  import lcfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [7:0]        in_rx_byte,
  input  logic [RIDX_W-1:0] in_read_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic              out_status,
  output logic [SEND_W-1:0] out_send_count,
  output logic [7:0]        out_read_value
);

  cmd_t  cmd;
  stat_t stat;

  lcfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  lcfp_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_rx_byte     (in_rx_byte),
    .in_read_index  (in_read_index),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_send_count (out_send_count),
    .out_read_value (out_read_value)
  );

endmodule
